// File: hw/rtl/sts_pkg.sv
// Shared types, constants and the sine table for the segment tone synthesizer.
// No dependencies; the divider, datapath, sequencer, top level and testbench import this package.
package sts_pkg;

   // Widths
   localparam int INDEX_BITS  = 24;
   localparam int SINE_BITS   = 10;
   localparam int SINE_ENTRIES = 1 << SINE_BITS;
   localparam int CSR_ADDR_W  = 5;

   // Iterative divider geometry: numerator is a 32-bit value times a sample index
   localparam int DIV_NUM_W   = 32 + INDEX_BITS;
   localparam int DIV_STEPS   = 4;
   localparam int DIV_ITERS   = (DIV_NUM_W + DIV_STEPS - 1) / DIV_STEPS;
   localparam int DIV_PAD_W   = DIV_ITERS * DIV_STEPS;
   localparam int DIV_CNT_W   = $clog2(DIV_ITERS + 1);

   // Arithmetic constants
   localparam logic [16:0] ONE_Q16    = 17'h10000;
   localparam logic [31:0] LCG_MUL    = 32'd1664525;
   localparam logic [31:0] LCG_ADD    = 32'd1013904223;
   localparam logic [23:0] NOISE_FULL = 24'hFFFFFF;
   localparam logic [15:0] PCM_SCALE  = 16'd32767;
   localparam logic [31:0] HALF_TURN  = 32'h8000_0000;

   // Waveform and envelope codes
   localparam logic [1:0] WAVE_SINE     = 2'd0;
   localparam logic [1:0] WAVE_SQUARE   = 2'd1;
   localparam logic [1:0] WAVE_TRIANGLE = 2'd2;
   localparam logic [1:0] WAVE_NOISE    = 2'd3;
   localparam logic [1:0] ENV_FLAT      = 2'd0;
   localparam logic [1:0] ENV_DECAY     = 2'd1;
   localparam logic [1:0] ENV_BELL      = 2'd2;

   // Register indexes (byte address = 4 * index)
   localparam logic [2:0] REG_START_STEP = 3'd0;
   localparam logic [2:0] REG_END_STEP   = 3'd1;
   localparam logic [2:0] REG_GAIN       = 3'd2;
   localparam logic [2:0] REG_WAVE       = 3'd3;
   localparam logic [2:0] REG_ENVELOPE   = 3'd4;
   localparam logic [2:0] REG_SEG_LEN    = 3'd5;
   localparam logic [2:0] REG_CHANNELS   = 3'd6;

   // Register reset values
   localparam logic [16:0] GAIN_RESET     = 17'd13107;
   localparam logic [1:0]  CHANNELS_RESET = 2'd1;

   typedef struct packed {
      logic [31:0]           start_step;
      logic [31:0]           end_step;
      logic [16:0]           gain;
      logic [1:0]            wave;
      logic [1:0]            envelope;
      logic [INDEX_BITS-1:0] seg_len;
      logic [1:0]            channels;
   } cfg_type;

   typedef enum logic [3:0] {
      OP_NONE,
      OP_ACCEPT,
      OP_PREP,
      OP_WAVE,
      OP_STEP_DIV,
      OP_STEP_SET,
      OP_ENV_DIV,
      OP_ENV_BASE,
      OP_ENV_SQ,
      OP_MAG1,
      OP_MAG2,
      OP_MAG3,
      OP_EMIT0,
      OP_EMIT1
   } dp_op_type;

   typedef struct packed {
      dp_op_type op;
   } dp_cmd_type;

   typedef struct packed {
      logic in_range;
      logic div_busy;
      logic env_div;
      logic out_free;
      logic two_chans;
   } dp_status_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_CHECK,
      ST_PREP,
      ST_WAVE,
      ST_STEP_DIV,
      ST_STEP_WAIT,
      ST_STEP_SET,
      ST_ENV_DIV,
      ST_ENV_WAIT,
      ST_ENV_BASE,
      ST_ENV_SQ,
      ST_MAG1,
      ST_MAG2,
      ST_MAG3,
      ST_EMIT0,
      ST_EMIT1
   } ctrl_state_type;

   typedef logic [16:0] sine_rom_type [SINE_ENTRIES];

   // Quarter-wave odd polynomial, Q16 magnitude, one entry per table phase
   function automatic sine_rom_type build_sine_rom();
      sine_rom_type      rom;
      logic [31:0]       p;
      longint unsigned   x;
      longint unsigned   x2;
      longint unsigned   t;
      longint unsigned   s;
      for (int k = 0; k < SINE_ENTRIES; k++) begin
         p  = 32'(k) << (32 - SINE_BITS);
         x  = longint'(p[29:14]);
         if (p[30]) begin
            x = 64'd65536 - x;
         end
         x2 = (x * x) >> 16;
         t  = 64'd11;
         t  = 64'd307 - ((x2 * t) >> 16);
         t  = 64'd5223 - ((x2 * t) >> 16);
         t  = 64'd42334 - ((x2 * t) >> 16);
         t  = 64'd102944 - ((x2 * t) >> 16);
         s  = (x * t) >> 16;
         if (s > 64'd65536) begin
            s = 64'd65536;
         end
         rom[k] = 17'(s);
      end
      return rom;
   endfunction

   localparam sine_rom_type SINE_ROM = build_sine_rom();

endpackage

// File: hw/rtl/sts_if.sv
// Valid/ready channel interfaces for the tone synthesizer request and response.
// No dependencies.
interface sts_req_if;
   logic valid;
   logic ready;
   logic new_sound;
   logic new_segment;

   modport source (output valid, output new_sound, output new_segment, input ready);
   modport sink   (input valid, input new_sound, input new_segment, output ready);
endinterface

interface sts_rsp_if;
   logic               valid;
   logic               ready;
   logic signed [15:0] sample;
   logic               channel;
   logic               last_channel;
   logic               segment_done;

   modport source (output valid, output sample, output channel, output last_channel,
                   output segment_done, input ready);
   modport sink   (input valid, input sample, input channel, input last_channel,
                   input segment_done, output ready);
endinterface

// File: hw/rtl/sts_divider.sv
// Iterative restoring divider, DIV_STEPS quotient bits per cycle.
// Depends on sts_pkg.
module sts_divider (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic [sts_pkg::DIV_NUM_W-1:0]  numer,
   input  logic [sts_pkg::INDEX_BITS-1:0] denom,
   output logic                          busy,
   output logic [sts_pkg::DIV_NUM_W-1:0]  quot
);
   import sts_pkg::*;

   logic [DIV_PAD_W-1:0]  quot_ff, quot_in;
   logic [INDEX_BITS-1:0] rem_ff, rem_in;
   logic [INDEX_BITS-1:0] denom_ff;
   logic [DIV_CNT_W-1:0]  count_ff;
   logic [INDEX_BITS:0]   trial;

   // A few restoring steps per cycle; quotient bits shift in behind the numerator
   always_comb begin
      rem_in  = rem_ff;
      quot_in = quot_ff;
      trial   = '0;
      for (int i = 0; i < DIV_STEPS; i++) begin
         trial   = {rem_in, quot_in[DIV_PAD_W-1]};
         quot_in = {quot_in[DIV_PAD_W-2:0], 1'b0};
         if (trial >= {1'b0, denom_ff}) begin
            trial      = trial - {1'b0, denom_ff};
            quot_in[0] = 1'b1;
         end
         rem_in = trial[INDEX_BITS-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else if (start) begin
         count_ff <= DIV_CNT_W'(DIV_ITERS);
      end else if (count_ff != '0) begin
         count_ff <= count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         quot_ff  <= DIV_PAD_W'(numer);
         rem_ff   <= '0;
         denom_ff <= denom;
      end else if (count_ff != '0) begin
         quot_ff <= quot_in;
         rem_ff  <= rem_in;
      end
   end

   assign busy = (count_ff != '0);
   assign quot = quot_ff[DIV_NUM_W-1:0];

endmodule

// File: hw/rtl/sts_datapath.sv
// Tone synthesizer datapath: phase, noise and index state, waveform, envelope,
// gain scaling and the response register. Depends on sts_pkg, sts_if, sts_divider.
module sts_datapath (
   input  logic                   clock,
   input  logic                   reset,
   input  sts_pkg::cfg_type       cfg,
   input  sts_pkg::dp_cmd_type    cmd,
   output sts_pkg::dp_status_type status,
   sts_req_if.sink                req_if,
   sts_rsp_if.source              rsp_if
);
   import sts_pkg::*;

   // Tone state
   logic [31:0]           phase_ff;
   logic [31:0]           seed_ff;
   logic [INDEX_BITS-1:0] index_ff;

   // Per-item working registers
   logic [INDEX_BITS-1:0] span_ff;
   logic                  done_ff;
   logic                  desc_ff;
   logic [DIV_NUM_W-1:0]  prod_ff;
   logic [31:0]           step_ff;
   logic signed [17:0]    value_ff;
   logic [16:0]           base_ff;
   logic [16:0]           env_ff;
   logic [32:0]           mag_ff;
   logic signed [15:0]    pcm_ff;

   // Response register
   logic                  rsp_valid_ff;
   logic signed [15:0]    rsp_sample_ff;
   logic                  rsp_channel_ff;
   logic                  rsp_last_ff;
   logic                  rsp_done_ff;

   // Divider hookup
   logic                  div_start;
   logic [DIV_NUM_W-1:0]  div_numer;
   logic                  div_busy;
   logic [DIV_NUM_W-1:0]  div_quot;

   // Combinational helpers
   logic [31:0]           diff;
   logic [16:0]           sine_mag;
   logic [31:0]           tri_dist;
   logic signed [19:0]    tri_val;
   logic [26:0]           noise_x;
   logic [23:0]           noise_abs;
   logic [24:0]           noise_rem;
   logic [16:0]           noise_q;
   logic signed [17:0]    wave_val;
   logic [31:0]           bell_phase;
   logic [16:0]           env_base;
   logic [16:0]           abs_val;
   logic [16:0]           gain_sat;
   logic [33:0]           env_sq;
   logic [49:0]           mag_env;
   logic [47:0]           mag_pcm;
   logic [14:0]           pcm_mag;
   logic                  out_free;

   sts_divider u_divider (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .numer (div_numer),
      .denom (span_ff),
      .busy  (div_busy),
      .quot  (div_quot)
   );

   // Sweep distance between start and end increments
   assign diff = (cfg.end_step < cfg.start_step) ? (cfg.start_step - cfg.end_step)
                                                 : (cfg.end_step - cfg.start_step);

   // Divider operand select: sweep offset, decay fraction or bell phase
   assign div_start = (cmd.op == OP_STEP_DIV) || (cmd.op == OP_ENV_DIV);
   always_comb begin
      if (cmd.op == OP_STEP_DIV) begin
         div_numer = prod_ff;
      end else if (cfg.envelope == ENV_DECAY) begin
         div_numer = DIV_NUM_W'({span_ff - index_ff, 16'b0});
      end else begin
         div_numer = DIV_NUM_W'({index_ff, 31'b0});
      end
   end

   // Waveform value from the current phase or the advanced noise seed
   assign sine_mag  = SINE_ROM[phase_ff[31 -: SINE_BITS]];
   assign tri_dist  = phase_ff[31] ? {1'b0, phase_ff[30:0]} : (HALF_TURN - phase_ff);
   assign tri_val   = 20'sd65536 - $signed({2'b00, tri_dist[31:14]});
   assign noise_x   = {2'b00, seed_ff[31:8], 1'b0} - {3'b000, NOISE_FULL};
   assign noise_abs = noise_x[26] ? 24'(-noise_x) : noise_x[23:0];
   // a * 2^16 / (2^24 - 1): quotient estimate a >> 8, one correction step
   assign noise_rem = {1'b0, noise_abs[7:0], 16'b0} + {9'b0, noise_abs[23:8]};
   assign noise_q   = (noise_rem >= {1'b0, NOISE_FULL}) ? ({1'b0, noise_abs[23:8]} + 17'd1)
                                                        : {1'b0, noise_abs[23:8]};
   always_comb begin
      case (cfg.wave)
         WAVE_SQUARE:   wave_val = phase_ff[31] ? -18'sd65536 : 18'sd65536;
         WAVE_TRIANGLE: wave_val = tri_val[17:0];
         WAVE_NOISE:    wave_val = noise_x[26] ? -$signed({1'b0, noise_q})
                                               : $signed({1'b0, noise_q});
         default:       wave_val = phase_ff[31] ? -$signed({1'b0, sine_mag})
                                                : $signed({1'b0, sine_mag});
      endcase
   end

   // Envelope base: decay fraction, bell sine magnitude, or unity
   assign bell_phase = (span_ff == '0) ? 32'd0 : div_quot[31:0];
   always_comb begin
      case (cfg.envelope)
         ENV_DECAY: env_base = (span_ff == '0) ? ONE_Q16 : div_quot[16:0];
         ENV_BELL:  env_base = SINE_ROM[bell_phase[31 -: SINE_BITS]];
         default:   env_base = ONE_Q16;
      endcase
   end

   assign env_sq   = base_ff * base_ff;
   assign abs_val  = value_ff[17] ? 17'(-value_ff) : value_ff[16:0];
   assign gain_sat = cfg.gain[16] ? ONE_Q16 : cfg.gain;
   assign mag_env  = mag_ff * env_ff;
   assign mag_pcm  = mag_ff * PCM_SCALE;
   assign pcm_mag  = mag_pcm[46:32];

   // Tone state and per-item work registers
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= '0;
         seed_ff  <= 32'd1;
         index_ff <= '0;
      end else begin
         case (cmd.op)
            OP_ACCEPT: begin
               if (req_if.new_sound) begin
                  phase_ff <= '0;
                  seed_ff  <= 32'd1;
               end
               if (req_if.new_segment) begin
                  index_ff <= '0;
               end
            end
            OP_PREP: seed_ff <= 32'(seed_ff * LCG_MUL) + LCG_ADD;
            OP_MAG3: begin
               phase_ff <= phase_ff + step_ff;
               index_ff <= index_ff + 1'b1;
            end
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      case (cmd.op)
         OP_PREP: begin
            span_ff <= cfg.seg_len - 1'b1;
            done_ff <= (index_ff == cfg.seg_len - 1'b1);
            desc_ff <= (cfg.end_step < cfg.start_step);
            prod_ff <= DIV_NUM_W'(diff) * DIV_NUM_W'(index_ff);
         end
         OP_WAVE:     value_ff <= wave_val;
         OP_STEP_SET: begin
            if (span_ff == '0) begin
               step_ff <= cfg.start_step;
            end else if (desc_ff) begin
               step_ff <= cfg.start_step - div_quot[31:0];
            end else begin
               step_ff <= cfg.start_step + div_quot[31:0];
            end
         end
         OP_ENV_BASE: base_ff <= env_base;
         OP_ENV_SQ:   env_ff  <= env_sq[32:16];
         OP_MAG1:     mag_ff  <= abs_val * gain_sat;
         OP_MAG2:     mag_ff  <= mag_env[48:16];
         OP_MAG3: begin
            if (step_ff == '0) begin
               pcm_ff <= '0;
            end else if (value_ff[17]) begin
               pcm_ff <= -$signed({1'b0, pcm_mag});
            end else begin
               pcm_ff <= $signed({1'b0, pcm_mag});
            end
         end
         default: ;
      endcase
   end

   // Response register: one copy per channel, held until taken
   assign out_free = !rsp_valid_ff || rsp_if.ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if ((cmd.op == OP_EMIT0) || (cmd.op == OP_EMIT1)) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_if.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if ((cmd.op == OP_EMIT0) || (cmd.op == OP_EMIT1)) begin
         rsp_sample_ff  <= pcm_ff;
         rsp_channel_ff <= (cmd.op == OP_EMIT1);
         rsp_last_ff    <= (cmd.op == OP_EMIT1) || !cfg.channels[1];
         rsp_done_ff    <= done_ff;
      end
   end

   assign rsp_if.valid        = rsp_valid_ff;
   assign rsp_if.sample       = rsp_sample_ff;
   assign rsp_if.channel      = rsp_channel_ff;
   assign rsp_if.last_channel = rsp_last_ff;
   assign rsp_if.segment_done = rsp_done_ff;

   assign status.in_range  = (index_ff < cfg.seg_len);
   assign status.div_busy  = div_busy;
   assign status.env_div   = (cfg.envelope == ENV_DECAY) || (cfg.envelope == ENV_BELL);
   assign status.out_free  = out_free;
   assign status.two_chans = cfg.channels[1];

endmodule

// File: hw/rtl/sts_ctrl.sv
// Tone synthesizer sequencer: accepts an item and steps the datapath through it.
// Depends on sts_pkg.
module sts_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  sts_pkg::dp_status_type status,
   output sts_pkg::dp_cmd_type    cmd
);
   import sts_pkg::*;

   ctrl_state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Next state and datapath command
   always_comb begin
      state_in  = state_ff;
      cmd.op    = OP_NONE;
      req_ready = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.op   = OP_ACCEPT;
               state_in = ST_CHECK;
            end
         end
         ST_CHECK:     state_in = status.in_range ? ST_PREP : ST_IDLE;
         ST_PREP: begin
            cmd.op   = OP_PREP;
            state_in = ST_WAVE;
         end
         ST_WAVE: begin
            cmd.op   = OP_WAVE;
            state_in = ST_STEP_DIV;
         end
         ST_STEP_DIV: begin
            cmd.op   = OP_STEP_DIV;
            state_in = ST_STEP_WAIT;
         end
         ST_STEP_WAIT: begin
            if (!status.div_busy) begin
               state_in = ST_STEP_SET;
            end
         end
         ST_STEP_SET: begin
            cmd.op   = OP_STEP_SET;
            state_in = status.env_div ? ST_ENV_DIV : ST_ENV_BASE;
         end
         ST_ENV_DIV: begin
            cmd.op   = OP_ENV_DIV;
            state_in = ST_ENV_WAIT;
         end
         ST_ENV_WAIT: begin
            if (!status.div_busy) begin
               state_in = ST_ENV_BASE;
            end
         end
         ST_ENV_BASE: begin
            cmd.op   = OP_ENV_BASE;
            state_in = ST_ENV_SQ;
         end
         ST_ENV_SQ: begin
            cmd.op   = OP_ENV_SQ;
            state_in = ST_MAG1;
         end
         ST_MAG1: begin
            cmd.op   = OP_MAG1;
            state_in = ST_MAG2;
         end
         ST_MAG2: begin
            cmd.op   = OP_MAG2;
            state_in = ST_MAG3;
         end
         ST_MAG3: begin
            cmd.op   = OP_MAG3;
            state_in = ST_EMIT0;
         end
         ST_EMIT0: begin
            if (status.out_free) begin
               cmd.op   = OP_EMIT0;
               state_in = status.two_chans ? ST_EMIT1 : ST_IDLE;
            end
         end
         ST_EMIT1: begin
            if (status.out_free) begin
               cmd.op   = OP_EMIT1;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

endmodule

// File: hw/rtl/segment_tone_synthesizer.sv
// Segment tone synthesizer top level: APB register file, sequencer and datapath.
// Depends on sts_pkg, sts_if, sts_ctrl, sts_datapath.
// A decay or bell envelope adds a second division before the first copy reaches
// the response register; the second channel copy enters it in the same cycle as
// the first is taken. The iterative divider (4 bits per cycle) sets the rate; one
// item is in flight at a time, and the next is taken once its last copy sits in
// the response register. An item outside the segment is retired with no response.
// Synchronous active-high reset restores phase 0, noise seed 1, index 0 and registers.
module segment_tone_synthesizer (
   input  logic                            clock,
   input  logic                            reset,
   sts_req_if.sink                         req_if,
   sts_rsp_if.source                       rsp_if,
   input  logic                            psel,
   input  logic                            penable,
   input  logic                            pwrite,
   input  logic [sts_pkg::CSR_ADDR_W-1:0]  paddr,
   input  logic [31:0]                     pwdata,
   output logic [31:0]                     prdata,
   output logic                            pready
);
   import sts_pkg::*;

   cfg_type       cfg_ff;
   dp_cmd_type    cmd;
   dp_status_type status;
   logic          csr_write;
   logic          req_ready;

   // Register writes
   assign pready    = 1'b1;
   assign csr_write = psel && penable && pwrite && pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.start_step <= '0;
         cfg_ff.end_step   <= '0;
         cfg_ff.gain       <= GAIN_RESET;
         cfg_ff.wave       <= WAVE_SINE;
         cfg_ff.envelope   <= ENV_FLAT;
         cfg_ff.seg_len    <= '0;
         cfg_ff.channels   <= CHANNELS_RESET;
      end else if (csr_write) begin
         unique case (paddr[4:2])
            REG_START_STEP: cfg_ff.start_step <= pwdata;
            REG_END_STEP:   cfg_ff.end_step   <= pwdata;
            REG_GAIN:       cfg_ff.gain       <= pwdata[16:0];
            REG_WAVE:       cfg_ff.wave       <= pwdata[1:0];
            REG_ENVELOPE:   cfg_ff.envelope   <= pwdata[1:0];
            REG_SEG_LEN:    cfg_ff.seg_len    <= pwdata[INDEX_BITS-1:0];
            REG_CHANNELS:   cfg_ff.channels   <= pwdata[1:0];
            default: ;
         endcase
      end
   end

   // Register reads
   always_comb begin
      unique case (paddr[4:2])
         REG_START_STEP: prdata = cfg_ff.start_step;
         REG_END_STEP:   prdata = cfg_ff.end_step;
         REG_GAIN:       prdata = 32'(cfg_ff.gain);
         REG_WAVE:       prdata = 32'(cfg_ff.wave);
         REG_ENVELOPE:   prdata = 32'(cfg_ff.envelope);
         REG_SEG_LEN:    prdata = 32'(cfg_ff.seg_len);
         REG_CHANNELS:   prdata = 32'(cfg_ff.channels);
         default:        prdata = '0;
      endcase
   end

   assign req_if.ready = req_ready;

   sts_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_if.valid),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd)
   );

   sts_datapath u_datapath (
      .clock  (clock),
      .reset  (reset),
      .cfg    (cfg_ff),
      .cmd    (cmd),
      .status (status),
      .req_if (req_if),
      .rsp_if (rsp_if)
   );

endmodule

// File: hw/rtl/sts_checker.sv
// Port-level checks for the segment tone synthesizer, bound to the top level.
// Depends on sts_if through the top level's ports.
module sts_checker (
   input logic               clock,
   input logic               reset,
   input logic               rsp_valid,
   input logic               rsp_ready,
   input logic signed [15:0] rsp_sample,
   input logic               rsp_channel,
   input logic               rsp_last_channel
);

   // Reset empties the response register
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("response valid after reset");

   // A stalled response holds its sample
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_sample))
      else $error("stalled response changed");

   // The second channel copy is always the last one
   a_ch1_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_channel |-> rsp_last_channel)
      else $error("channel 1 copy not marked last");

   // A non-final copy is followed at once by the channel 1 copy
   a_ch1_follows: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready && !rsp_last_channel |=> rsp_valid && rsp_channel)
      else $error("channel 1 copy did not follow");

endmodule

bind segment_tone_synthesizer sts_checker u_sts_checker (
   .clock            (clock),
   .reset            (reset),
   .rsp_valid        (rsp_if.valid),
   .rsp_ready        (rsp_if.ready),
   .rsp_sample       (rsp_if.sample),
   .rsp_channel      (rsp_if.channel),
   .rsp_last_channel (rsp_if.last_channel)
);

// File: tb/segment_tone_synthesizer_tb.sv
// Testbench for the segment tone synthesizer: register phases, a directed table
// of ticks, then random ticks, with every response checked against a local model.
// Depends on sts_pkg, sts_if and the segment_tone_synthesizer RTL.
`timescale 1ns / 100ps

module segment_tone_synthesizer_tb;
   import sts_pkg::*;

   typedef struct packed {
      logic signed [15:0] sample;
      logic               channel;
      logic               last_channel;
      logic               segment_done;
   } pcm_copy_type;

   typedef struct {
      logic        new_sound;
      logic        new_segment;
      logic        has_known;
      logic [15:0] known_sample;
   } tick_row_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
   logic [CSR_ADDR_W-1:0] paddr = '0;
   logic [31:0] pwdata = '0;
   logic [31:0] prdata;
   logic pready;

   sts_req_if req_if ();
   sts_rsp_if rsp_if ();

   segment_tone_synthesizer dut (
      .clock(clock), .reset(reset), .req_if(req_if), .rsp_if(rsp_if),
      .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
      .pwdata(pwdata), .prdata(prdata), .pready(pready)
   );

   always #5 clock = ~clock;

   // Tone state and register shadow
   logic [31:0] m_start, m_end, m_phase, m_seed;
   logic [16:0] m_gain;
   logic [1:0]  m_wave, m_env, m_chans;
   logic [23:0] m_len, m_index;

   pcm_copy_type pending_copies[$];
   int  failures = 0;
   bit  calm = 1'b0;       // no idling on either side
   bit  rsp_hold = 1'b0;   // long receiver hold-off request

   function automatic longint unsigned quarter_sine(logic [31:0] phase);
      logic [31:0] p;
      longint unsigned x, x2, t, s;
      p = {phase[31:22], 22'd0};
      x = p[29:14];
      if (p[30]) x = 65536 - x;
      x2 = (x * x) >> 16;
      t = 307 - ((x2 * 11) >> 16);
      t = 5223 - ((x2 * t) >> 16);
      t = 42334 - ((x2 * t) >> 16);
      t = 102944 - ((x2 * t) >> 16);
      s = (x * t) >> 16;
      if (s > 65536) s = 65536;
      return s;
   endfunction

   // Advance the model by one tick; push the expected copies
   task automatic synth_tick(input logic snd, input logic seg);
      longint unsigned n, j, span, step, env, gain, mag, omu, sm;
      longint signed   val, m;
      logic [31:0]     d;
      bit              neg;
      int              chans;
      pcm_copy_type    cp;
      logic [15:0]     pcm;
      if (snd) begin m_phase = 0; m_seed = 1; end
      if (seg) m_index = 0;
      n = m_len; j = m_index;
      if (j >= n) return;
      span = n - 1;
      if (span == 0) step = m_start;
      else if (m_end >= m_start) step = m_start + (longint'(m_end - m_start) * j) / span;
      else step = m_start - (longint'(m_start - m_end) * j) / span;
      m_seed = m_seed * LCG_MUL + LCG_ADD;
      case (m_wave)
         WAVE_SQUARE: val = (m_phase < HALF_TURN) ? 65536 : -65536;
         WAVE_TRIANGLE: begin
            d = (m_phase >= HALF_TURN) ? m_phase - HALF_TURN : HALF_TURN - m_phase;
            val = 65536 - longint'(d >> 14);
         end
         WAVE_NOISE: begin
            m = m_seed >> 8;
            val = ((2 * m - 16777215) * 65536) / 16777215;
         end
         default: begin
            val = quarter_sine(m_phase);
            if (m_phase[31]) val = -val;
         end
      endcase
      if (m_env == ENV_DECAY) begin
         omu = (span == 0) ? 65536 : ((span - j) * 65536) / span;
         env = (omu * omu) >> 16;
      end else if (m_env == ENV_BELL) begin
         sm = (span == 0) ? 0 : quarter_sine(32'((j << 31) / span));
         env = (sm * sm) >> 16;
      end else env = 65536;
      gain = (m_gain > ONE_Q16) ? 65536 : m_gain;
      neg = val < 0;
      mag = neg ? -val : val;
      if (step == 0) pcm = 0;
      else begin
         mag = ((mag * gain) * env) >> 16;
         mag = (mag * PCM_SCALE) >> 32;
         pcm = neg ? -16'(mag) : 16'(mag);
      end
      m_phase = m_phase + 32'(step);
      m_index = 24'(j + 1);
      chans = (m_chans == 0) ? 1 : (m_chans > 2 ? 2 : m_chans);
      for (int c = 0; c < chans; c++) begin
         cp.sample = pcm;
         cp.channel = 1'(c);
         cp.last_channel = (c + 1 == chans);
         cp.segment_done = (j == span);
         pending_copies.push_back(cp);
      end
   endtask

   // Register write; model shadow follows
   task automatic csr_write(input logic [2:0] idx, input logic [31:0] value);
      @(negedge clock);
      psel <= 1'b1; pwrite <= 1'b1; paddr <= CSR_ADDR_W'({idx, 2'b00}); pwdata <= value;
      @(negedge clock);
      penable <= 1'b1;
      @(posedge clock);
      while (!pready) @(posedge clock);
      case (idx)
         REG_START_STEP: m_start = value;
         REG_END_STEP:   m_end = value;
         REG_GAIN:       m_gain = value[16:0];
         REG_WAVE:       m_wave = value[1:0];
         REG_ENVELOPE:   m_env = value[1:0];
         REG_SEG_LEN:    m_len = value[23:0];
         REG_CHANNELS:   m_chans = value[1:0];
         default: ;
      endcase
      @(negedge clock);
      psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
   endtask

   task automatic wait_drained();
      while (pending_copies.size() != 0) @(posedge clock);
      repeat (60) @(posedge clock);
   endtask

   // Offer one tick; returns when accepted
   task automatic send_tick(input logic snd, input logic seg);
      @(negedge clock);
      while (!calm && $urandom_range(99) < 34) begin
         req_if.valid <= 1'b0;
         @(negedge clock);
      end
      req_if.valid <= 1'b1;
      req_if.new_sound <= snd;
      req_if.new_segment <= seg;
      @(posedge clock);
      while (!req_if.ready) @(posedge clock);
      synth_tick(snd, seg);
      @(negedge clock);
      req_if.valid <= 1'b0;
   endtask

   task automatic random_setup(input int len);
      csr_write(REG_START_STEP, ($urandom_range(7) == 0) ? 32'd0 : $urandom);
      csr_write(REG_END_STEP, ($urandom_range(7) == 0) ? 32'h8000_0000 : $urandom);
      csr_write(REG_GAIN, $urandom_range(131071));
      csr_write(REG_WAVE, $urandom_range(3));
      csr_write(REG_ENVELOPE, $urandom_range(3));
      csr_write(REG_SEG_LEN, 32'(len));
      csr_write(REG_CHANNELS, $urandom_range(3));
   endtask

   // Receiver: random stalls, calm stretches and one long hold-off
   initial begin
      rsp_if.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (rsp_hold) begin
            rsp_if.ready <= 1'b0;
            repeat (300) @(negedge clock);
            rsp_hold = 1'b0;
         end
         rsp_if.ready <= calm ? 1'b1 : ($urandom_range(99) >= 34);
      end
   end

   // Response checker
   always @(posedge clock) begin
      pcm_copy_type want;
      if (!reset && rsp_if.valid && rsp_if.ready) begin
         if (pending_copies.size() == 0) begin
            $error("unexpected response sample=%0d", rsp_if.sample);
            failures++;
         end else begin
            want = pending_copies.pop_front();
            if (rsp_if.sample !== want.sample) begin
               $error("sample: expected %0d actual %0d", want.sample, rsp_if.sample);
               failures++;
            end
            if (rsp_if.channel !== want.channel) begin
               $error("channel: expected %0d actual %0d", want.channel, rsp_if.channel);
               failures++;
            end
            if (rsp_if.last_channel !== want.last_channel) begin
               $error("last_channel: expected %0d actual %0d",
                      want.last_channel, rsp_if.last_channel);
               failures++;
            end
            if (rsp_if.segment_done !== want.segment_done) begin
               $error("segment_done: expected %0d actual %0d",
                      want.segment_done, rsp_if.segment_done);
               failures++;
            end
         end
      end
   end

   // Directed rows: new sound and new segment flags; no row sets a known value
   tick_row_type directed_rows[] = '{
      '{1'b1, 1'b1, 1'b0, 16'd0},
      '{1'b0, 1'b0, 1'b0, 16'd0},
      '{1'b0, 1'b1, 1'b0, 16'd0},
      '{1'b1, 1'b0, 1'b0, 16'd0},
      '{1'b0, 1'b0, 1'b0, 16'd0},
      '{1'b0, 1'b0, 1'b0, 16'd0}
   };

   // Stimulus
   initial begin
      int len;
      bit snd;
      pcm_copy_type got;
      req_if.valid = 1'b0;
      req_if.new_sound = 1'b0;
      req_if.new_segment = 1'b0;
      m_start = 0; m_end = 0; m_gain = GAIN_RESET; m_wave = WAVE_SINE;
      m_env = ENV_FLAT; m_len = 0; m_chans = CHANNELS_RESET;
      m_phase = 0; m_seed = 1; m_index = 0;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // After reset the segment is empty: no responses at all
      foreach (directed_rows[r]) send_tick(directed_rows[r].new_sound,
                                           directed_rows[r].new_segment);
      wait_drained();

      // Silence: zero step, full gain, square, two channels
      csr_write(REG_GAIN, 32'd65536);
      csr_write(REG_WAVE, 32'(WAVE_SQUARE));
      csr_write(REG_SEG_LEN, 32'd3);
      csr_write(REG_CHANNELS, 32'd2);
      for (int r = 0; r < 3; r++) begin
         send_tick(1'b0, r == 0);
         if (r == 0 && pending_copies.size() > 0) begin
            got = pending_copies[0];
            if (got.sample !== 16'd0) begin
               $error("sample: expected 0 actual %0d", got.sample);
               failures++;
            end
         end
      end
      wait_drained();

      // Every wave and envelope at the extremes, single-sample and long segments
      for (int w = 0; w < 4; w++) begin
         for (int e = 0; e < 4; e++) begin
            csr_write(REG_WAVE, 32'(w));
            csr_write(REG_ENVELOPE, 32'(e));
            csr_write(REG_START_STEP, (e & 1) ? 32'h8000_0000 : 32'h0100_0000);
            csr_write(REG_END_STEP, (e & 1) ? 32'd1 : 32'hFFFF_FFFF);
            csr_write(REG_GAIN, (w == 3) ? 32'h1FFFF : 32'd65536);
            csr_write(REG_SEG_LEN, (e == 3) ? 32'd1 : 32'hFFFFFF);
            csr_write(REG_CHANNELS, (w == 0) ? 32'd0 : 32'd3);
            send_tick(w == 0, 1'b1);
            send_tick(1'b0, 1'b0);
            wait_drained();
         end
      end

      // Random segments; mostly short and well formed
      for (int s = 0; s < 60; s++) begin
         len = ($urandom_range(9) == 0) ? $urandom_range(24'hFFFFFF) : $urandom_range(1, 12);
         random_setup(len);
         calm = (s >= 20 && s < 28);
         if (s == 40) rsp_hold = 1'b1;
         for (int k = 0; k < 10; k++) begin
            snd = ($urandom_range(19) == 0);
            send_tick(snd, k == 0 || $urandom_range(15) == 0);
         end
         // Sender pause until the block is drained
         wait_drained();
      end
      calm = 1'b0;
      wait_drained();

      if (failures == 0 && pending_copies.size() == 0)
         $display("Test completed successfully");
      else
         $display("Test completed with failures");
      $finish;
   end

   // Run limit
   initial begin
      #20ms;
      $display("Test completed with failures");
      $finish;
   end

endmodule
